// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/cfq_pkg.sv
// ---------------------------------------------------------------------------
// cfq_pkg
// Shared types, codes and defaults of the two-class age-ordered FIFO.
// ---------------------------------------------------------------------------
package cfq_pkg;

  // Port field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PAYLOAD_W = 16;
  localparam int unsigned STAMP_W   = 16;

  // Parameter defaults
  localparam int unsigned DEF_QUEUE_DEPTH  = 16;
  localparam int unsigned DEF_PAYLOAD_BITS = 16;
  localparam int unsigned DEF_STAMP_BITS   = 16;

  // Item classes
  localparam logic CLASS_FIRST  = 1'b0;
  localparam logic CLASS_SECOND = 1'b1;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ENQ       = 2'd0,
    OP_DEQ_ANY   = 2'd1,
    OP_DEQ_CLASS = 2'd2,
    OP_IGNORE    = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  // Occupancy flags of one class queue
  typedef struct packed {
    logic empty;
    logic full;
  } qflags_t;

endpackage

// File: hdl/cfq_mem.sv
// ---------------------------------------------------------------------------
// cfq_mem
// Single-port-write, single-read synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module cfq_mem #(
  parameter int unsigned DEPTH  = cfq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned WIDTH  = cfq_pkg::DEF_PAYLOAD_BITS + cfq_pkg::DEF_STAMP_BITS,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/cfq_ptrs.sv
// ---------------------------------------------------------------------------
// cfq_ptrs
// Head, tail and fill count of one circular class queue.
// ---------------------------------------------------------------------------
module cfq_ptrs #(
  parameter int unsigned DEPTH  = cfq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned PTR_W  = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             pop_i,
  output logic [PTR_W-1:0] head_o,
  output logic [PTR_W-1:0] tail_o,
  output cfq_pkg::qflags_t flags_o
);
  import cfq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Advance pointers; push and pop never come in the same cycle
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d  = ptr_next(tail_q);
      count_d = count_q + CNT_W'(1);
    end else if (pop_i) begin
      head_d  = ptr_next(head_q);
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign head_o        = head_q;
  assign tail_o        = tail_q;
  assign flags_o.empty = (count_q == '0);
  assign flags_o.full  = (count_q == CNT_W'(DEPTH));

endmodule

// File: hdl/two_class_fifo_oldest_first.sv
// Two FIFOs, one per item class, sharing one arrival stamp counter. An
// enqueue beat stores its payload and the current stamp at its class tail and
// returns that stamp unless the class is full; a dequeue-any beat pops the
// older head (serial-number compare, so stamps may wrap) or the only
// non-empty head; a dequeue-of-class beat pops that class head. Every input
// beat gives exactly one result beat. Each item passes an accept cycle and an
// execute cycle: the accept cycle starts the registered read of both class
// heads, and the execute cycle that follows compares, pops or pushes and
// loads the output register. The execute cycle waits while the output
// register holds a beat that is stalled; a new item is accepted whenever the
// block is idle, even with a result still waiting. No clearing pass is needed
// after reset.
// ---------------------------------------------------------------------------
// two_class_fifo_oldest_first
// Top level: sequencer, stamp counter, class selection and output register.
// ---------------------------------------------------------------------------
module two_class_fifo_oldest_first #(
  parameter int unsigned QUEUE_DEPTH  = cfq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned PAYLOAD_BITS = cfq_pkg::DEF_PAYLOAD_BITS,
  parameter int unsigned STAMP_BITS   = cfq_pkg::DEF_STAMP_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cfq_pkg::OP_W-1:0]       op_i,
  input  logic                           item_class_i,
  input  logic [cfq_pkg::PAYLOAD_W-1:0]  payload_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cfq_pkg::STATUS_W-1:0]   status_o,
  output logic                           out_class_o,
  output logic [cfq_pkg::PAYLOAD_W-1:0]  out_payload_o,
  output logic [cfq_pkg::STAMP_W-1:0]    out_stamp_o
);
  import cfq_pkg::*;

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned ENTRY_W = PAYLOAD_BITS + STAMP_BITS;

  // Sequencer and captured beat
  state_e                  state_q, state_d;
  op_e                     op_q;
  logic                    cls_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [STAMP_BITS-1:0]   stamp_q;

  // Output register
  logic                    out_valid_q;
  status_e                 status_q;
  logic                    out_class_q;
  logic [PAYLOAD_W-1:0]    out_payload_q;
  logic [STAMP_W-1:0]      out_stamp_q;

  // Queue side
  logic [PTR_W-1:0]        head0, tail0, head1, tail1;
  qflags_t                 flags0, flags1;
  logic [ENTRY_W-1:0]      rd0, rd1;
  logic [ENTRY_W-1:0]      wr_entry;
  logic                    push0, push1, pop0, pop1;

  // Execute decision
  logic                    in_accept;
  logic                    exec_go;
  logic                    take;
  logic                    take_cls;
  logic                    enq_ok;
  status_e                 status_c;
  logic [STAMP_BITS-1:0]   stamp0, stamp1, stamp_diff;
  logic [ENTRY_W-1:0]      got;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign exec_go   = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  // Capture the beat on accept
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= op_e'(op_i);
      cls_q <= item_class_i;
      pay_q <= (PAYLOAD_BITS)'(payload_i);
    end
  end

  // Sequence accept and execute
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Serial-number compare of the two head stamps
  assign stamp0     = rd0[ENTRY_W-1:PAYLOAD_BITS];
  assign stamp1     = rd1[ENTRY_W-1:PAYLOAD_BITS];
  assign stamp_diff = stamp0 - stamp1;

  // Choose the queue to pop and the status
  always_comb begin
    take     = 1'b0;
    take_cls = CLASS_FIRST;
    enq_ok   = 1'b0;
    status_c = STATUS_OK;
    unique case (op_q)
      OP_ENQ: begin
        if ((cls_q == CLASS_FIRST) ? flags0.full : flags1.full) begin
          status_c = STATUS_FULL;
        end else begin
          enq_ok = 1'b1;
        end
      end
      OP_DEQ_ANY: begin
        priority if (!flags0.empty && !flags1.empty) begin
          take     = 1'b1;
          take_cls = stamp_diff[STAMP_BITS-1] ? CLASS_FIRST : CLASS_SECOND;
        end else if (!flags0.empty) begin
          take     = 1'b1;
          take_cls = CLASS_FIRST;
        end else if (!flags1.empty) begin
          take     = 1'b1;
          take_cls = CLASS_SECOND;
        end else begin
          status_c = STATUS_EMPTY;
        end
      end
      OP_DEQ_CLASS: begin
        if ((cls_q == CLASS_FIRST) ? flags0.empty : flags1.empty) begin
          status_c = STATUS_EMPTY;
        end else begin
          take     = 1'b1;
          take_cls = cls_q;
        end
      end
      OP_IGNORE: begin
        status_c = STATUS_OK;
      end
      default: status_c = STATUS_OK;
    endcase
  end

  assign push0 = exec_go && enq_ok && (cls_q == CLASS_FIRST);
  assign push1 = exec_go && enq_ok && (cls_q == CLASS_SECOND);
  assign pop0  = exec_go && take && (take_cls == CLASS_FIRST);
  assign pop1  = exec_go && take && (take_cls == CLASS_SECOND);
  assign got   = (take_cls == CLASS_FIRST) ? rd0 : rd1;
  assign wr_entry = {stamp_q, pay_q};

  // Advance the arrival stamp on a stored enqueue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
    end else if (push0 || push1) begin
      stamp_q <= stamp_q + STAMP_BITS'(1);
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      status_q      <= status_c;
      out_class_q   <= take ? take_cls : 1'b0;
      out_payload_q <= take ? PAYLOAD_W'(got[PAYLOAD_BITS-1:0]) : '0;
      if (take) begin
        out_stamp_q <= STAMP_W'(got[ENTRY_W-1:PAYLOAD_BITS]);
      end else if (enq_ok) begin
        out_stamp_q <= STAMP_W'(stamp_q);
      end else begin
        out_stamp_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_class_o   = out_class_q;
  assign out_payload_o = out_payload_q;
  assign out_stamp_o   = out_stamp_q;

  // Class queue pointers
  cfq_ptrs #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ptrs0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push0),
    .pop_i   (pop0),
    .head_o  (head0),
    .tail_o  (tail0),
    .flags_o (flags0)
  );

  cfq_ptrs #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ptrs1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push1),
    .pop_i   (pop1),
    .head_o  (head1),
    .tail_o  (tail1),
    .flags_o (flags1)
  );

  // Class entry memories; heads are read on accept
  cfq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_mem0 (
    .clk_i     (clk_i),
    .wr_en_i   (push0),
    .wr_addr_i (tail0),
    .wr_data_i (wr_entry),
    .rd_en_i   (in_accept),
    .rd_addr_i (head0),
    .rd_data_o (rd0)
  );

  cfq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_mem1 (
    .clk_i     (clk_i),
    .wr_en_i   (push1),
    .wr_addr_i (tail1),
    .wr_data_i (wr_entry),
    .rd_en_i   (in_accept),
    .rd_addr_i (head1),
    .rd_data_o (rd1)
  );

endmodule

// File: hdl/cfq_checker.sv
// ---------------------------------------------------------------------------
// cfq_checker
// Port-level checks of the two-class FIFO, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [cfq_pkg::STATUS_W-1:0]   status_o,
  input logic                           out_class_o,
  input logic [cfq_pkg::PAYLOAD_W-1:0]  out_payload_o,
  input logic [cfq_pkg::STAMP_W-1:0]    out_stamp_o
);
  import cfq_pkg::*;

  // Hold a stalled result beat
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Busy for the execute cycle after an accepted beat
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // Rejected or empty results carry no item
  `ASSERT_IMPLIES(a_fail_zero, clk_i, rst_ni,
    out_valid_o && (status_o == STATUS_FULL || status_o == STATUS_EMPTY),
    out_class_o == 1'b0 && out_payload_o == '0 && out_stamp_o == '0)

  // Only defined status codes leave the block
  `ASSERT_IMPLIES(a_status_code, clk_i, rst_ni, out_valid_o,
    status_o == STATUS_OK || status_o == STATUS_FULL || status_o == STATUS_EMPTY)

endmodule

bind two_class_fifo_oldest_first cfq_checker u_cfq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .out_class_o   (out_class_o),
  .out_payload_o (out_payload_o),
  .out_stamp_o   (out_stamp_o)
);

// File: verif/two_class_fifo_oldest_first_tb.sv
// ---------------------------------------------------------------------------
// two_class_fifo_oldest_first_tb
// Self-checking bench for the two-class FIFO with oldest-first dequeue.
// A local copy of both class queues and the stamp counter predicts every
// result beat. Directed tests cover empty, full, ignore and age ordering.
// Random traffic then runs in fill-heavy, balanced and drain-heavy phases.
// ---------------------------------------------------------------------------
module two_class_fifo_oldest_first_tb;
  import cfq_pkg::*;

  localparam int unsigned CLASS_DEPTH    = DEF_QUEUE_DEPTH;
  localparam int unsigned RANDOM_BEATS   = 1350;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [STAMP_W-1:0]   stamp;
  } slot_t;

  typedef struct packed {
    status_e              status;
    logic                 cls;
    logic [PAYLOAD_W-1:0] payload;
    logic [STAMP_W-1:0]   stamp;
  } outcome_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [OP_W-1:0]      op_i         = OP_IGNORE;
  logic                 item_class_i = CLASS_FIRST;
  logic [PAYLOAD_W-1:0] payload_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic                 out_class_o;
  logic [PAYLOAD_W-1:0] out_payload_o;
  logic [STAMP_W-1:0]   out_stamp_o;

  // Predicted class queues, stamp counter and pending outcomes
  slot_t              first_q[$];
  slot_t              second_q[$];
  logic [STAMP_W-1:0] stamp_ctr = '0;
  outcome_t           outcome_q[$];
  outcome_t           check_want;

  bit throttle_en = 1'b1;
  int fail_count  = 0;
  int quiet_cycles = 0;

  two_class_fifo_oldest_first dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .item_class_i  (item_class_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_class_o   (out_class_o),
    .out_payload_o (out_payload_o),
    .out_stamp_o   (out_stamp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one beat to the predicted queues and return its outcome
  function automatic outcome_t fifo_outcome(op_e op, logic cls, logic [PAYLOAD_W-1:0] pay);
    outcome_t res;
    slot_t    slot;
    logic     take_valid;
    logic     take_cls;
    logic [STAMP_W-1:0] diff;
    res        = '0;
    res.status = STATUS_OK;
    take_valid = 1'b0;
    take_cls   = CLASS_FIRST;
    case (op)
      OP_ENQ: begin
        if ((cls == CLASS_FIRST) ? (first_q.size() >= CLASS_DEPTH)
                                 : (second_q.size() >= CLASS_DEPTH)) begin
          res.status = STATUS_FULL;
        end else begin
          slot.payload = pay;
          slot.stamp   = stamp_ctr;
          if (cls == CLASS_FIRST) first_q.insert(first_q.size(), slot);
          else second_q.insert(second_q.size(), slot);
          res.stamp = stamp_ctr;
          stamp_ctr = stamp_ctr + 1'b1;
        end
      end
      OP_DEQ_ANY: begin
        // Older head wins by wrapped difference; ties go to the second class
        if (first_q.size() != 0 && second_q.size() != 0) begin
          diff       = first_q[0].stamp - second_q[0].stamp;
          take_cls   = diff[STAMP_W-1] ? CLASS_FIRST : CLASS_SECOND;
          take_valid = 1'b1;
        end else if (first_q.size() != 0) begin
          take_cls   = CLASS_FIRST;
          take_valid = 1'b1;
        end else if (second_q.size() != 0) begin
          take_cls   = CLASS_SECOND;
          take_valid = 1'b1;
        end else begin
          res.status = STATUS_EMPTY;
        end
      end
      OP_DEQ_CLASS: begin
        if ((cls == CLASS_FIRST) ? (first_q.size() != 0) : (second_q.size() != 0)) begin
          take_cls   = cls;
          take_valid = 1'b1;
        end else begin
          res.status = STATUS_EMPTY;
        end
      end
      default: ;
    endcase
    if (take_valid) begin
      if (take_cls == CLASS_FIRST) begin
        slot = first_q[0];
        first_q.delete(0);
      end else begin
        slot = second_q[0];
        second_q.delete(0);
      end
      res.cls     = take_cls;
      res.payload = slot.payload;
      res.stamp   = slot.stamp;
    end
    return res;
  endfunction

  // Drive one input beat, hold it until accepted, then record its outcome
  task automatic send_beat(op_e op, logic cls, logic [PAYLOAD_W-1:0] pay);
    if (throttle_en && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    item_class_i <= cls;
    payload_i    <= pay;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    outcome_q.insert(outcome_q.size(), fifo_outcome(op, cls, pay));
  endtask

  // Dequeues on an empty block, any and per class
  task automatic test_empty_dequeue();
    send_beat(OP_DEQ_ANY, CLASS_FIRST, 16'hFFFF);
    send_beat(OP_DEQ_CLASS, CLASS_FIRST, 16'h0000);
    send_beat(OP_DEQ_CLASS, CLASS_SECOND, 16'h1234);
  endtask

  // Age ordering across classes, one-sided fallback, ignored op
  task automatic test_age_order();
    send_beat(OP_ENQ, CLASS_FIRST, 16'h0000);
    send_beat(OP_ENQ, CLASS_SECOND, 16'hFFFF);
    send_beat(OP_ENQ, CLASS_FIRST, 16'h5A5A);
    send_beat(OP_DEQ_ANY, CLASS_SECOND, 16'h0000);
    send_beat(OP_DEQ_ANY, CLASS_FIRST, 16'h0000);
    send_beat(OP_DEQ_ANY, CLASS_SECOND, 16'hFFFF);
    send_beat(OP_IGNORE, CLASS_SECOND, 16'hFFFF);
    send_beat(OP_ENQ, CLASS_SECOND, 16'h8001);
    send_beat(OP_DEQ_CLASS, CLASS_SECOND, 16'h0000);
  endtask

  // Fill the second class until it rejects, then pop from the one-sided block
  task automatic test_class_full();
    repeat (CLASS_DEPTH + 1)
      send_beat(OP_ENQ, CLASS_SECOND, PAYLOAD_W'($urandom_range(65535)));
    send_beat(OP_DEQ_ANY, CLASS_FIRST, PAYLOAD_W'($urandom_range(65535)));
  endtask

  // Random traffic in phases of varying enqueue weight
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase;
    int unsigned enq_weight;
    int unsigned pick;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BEATS) begin
      case ($urandom_range(2))
        0:       enq_weight = 15;
        1:       enq_weight = 50;
        default: enq_weight = 85;
      endcase
      throttle_en = !(phase >= 10 && phase < 14);
      repeat (40) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          send_beat(OP_IGNORE, 1'($urandom_range(1)), PAYLOAD_W'($urandom_range(65535)));
        end else begin
          if ($urandom_range(99) < enq_weight)
            send_beat(OP_ENQ, 1'($urandom_range(1)), PAYLOAD_W'($urandom_range(65535)));
          else if ($urandom_range(1) == 0)
            send_beat(OP_DEQ_ANY, 1'($urandom_range(1)),
                      PAYLOAD_W'($urandom_range(65535)));
          else
            send_beat(OP_DEQ_CLASS, 1'($urandom_range(1)),
                      PAYLOAD_W'($urandom_range(65535)));
          sent++;
        end
      end
      phase++;
    end
    throttle_en = 1'b1;
  endtask

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= throttle_en && ($urandom_range(99) < 38);
  end

  // Compare each accepted result beat with the oldest pending outcome
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcome_q.size() == 0) begin
        $error("result beat with no outcome pending");
        fail_count++;
      end else begin
        check_want = outcome_q[0];
        outcome_q.delete(0);
        if (status_o !== check_want.status) begin
          $error("status: expected %0d, got %0d", check_want.status, status_o);
          fail_count++;
        end
        if (out_class_o !== check_want.cls) begin
          $error("out_class: expected %0d, got %0d", check_want.cls, out_class_o);
          fail_count++;
        end
        if (out_payload_o !== check_want.payload) begin
          $error("out_payload: expected 0x%04h, got 0x%04h", check_want.payload,
                 out_payload_o);
          fail_count++;
        end
        if (out_stamp_o !== check_want.stamp) begin
          $error("out_stamp: expected 0x%04h, got 0x%04h", check_want.stamp, out_stamp_o);
          fail_count++;
        end
      end
    end
  end

  // End the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_dequeue();
    test_age_order();
    test_class_full();
    test_random_traffic();
    // Drain outstanding results, then let the block settle
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
